### hdl/pse_pkg.sv
package pse_pkg;

	// Default depth of the operand stack.
	localparam int STACK_DEPTH_DEF = 16;

	// Data path width of a stack entry.
	localparam int WORD_W = 32;

	// Iterations of the radix-2 divider, one quotient bit each.
	localparam int DIV_STEPS = WORD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Character codes.
	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;
	localparam logic [7:0] SYM_EMPTY = 8'h24;
	localparam logic [7:0] SYM_ADD   = 8'h2B;
	localparam logic [7:0] SYM_SUB   = 8'h2D;
	localparam logic [7:0] SYM_MUL   = 8'h2A;
	localparam logic [7:0] SYM_DIV   = 8'h2F;

	// Value returned by a pop of an empty stack.
	localparam logic [WORD_W-1:0] EMPTY_WORD = {{(WORD_W-8){1'b0}}, SYM_EMPTY};

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     underflow;
		logic                     overflow;
		logic                     div_by_zero;
	} out_word_t;

	typedef struct packed {
		logic div_by_zero;
		logic overflow;
		logic underflow;
	} flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_L,
		ST_OPER,
		ST_EXEC,
		ST_DIV,
		ST_DIV_END,
		ST_FIN_RD,
		ST_FIN
	} state_t;

endpackage

### hdl/pse_ram.sv
module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Registered read; the read data holds until the next read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/postfix_stack_evaluator.sv
// Postfix evaluator: one expression character per word, one result word per expression.
// A digit is pushed when taken; an operator pops its right, then its left operand, and pushes
// the result, after 32 divider iterations for a nonzero divisor; the last character ends with a
// final pop into the result. A new word is taken only once the previous one is done, and a
// finished result that finds the result register still full holds the input until it drains.
// Reset (arst_n low, asynchronous): stack empty, error flags clear, no result pending.
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pse_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output pse_pkg::out_word_t out_word
);

	import pse_pkg::*;

	// Address width of the stack memory, and a counter wide enough to hold the depth itself.
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

	state_t state_q, state_d;

	logic [CW-1:0]     cnt_q;
	flags_t            flags_q;
	logic [7:0]        sym_q;
	logic              last_q;
	logic [WORD_W-1:0] right_q, left_q;
	logic              pop_mem_q;

	// Divider registers: partial remainder, quotient shift register and divisor magnitude.
	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;

	logic      out_valid_q;
	out_word_t out_word_q;

	// Control produced by the state machine.
	logic              pop_req, push_req, divz_set, emit;
	logic [WORD_W-1:0] push_data;

	// Stack memory signals.
	logic              ram_wr_en, ram_rd_en;
	logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
	logic [WORD_W-1:0] ram_rd_data;

	logic              accept, in_digit, empty, full;
	logic [CW-1:0]     cnt_dec;
	logic [WORD_W-1:0] pop_value;
	logic [WORD_W-1:0] abs_left, abs_right;
	logic [WORD_W:0]   rem_sh;
	logic              rem_ge;
	logic [WORD_W-1:0] quo_final;

	assign accept   = in_valid && in_ready;
	assign in_digit = (in_word.symbol >= SYM_ZERO) && (in_word.symbol <= SYM_NINE);
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q >= FULL_COUNT);
	assign cnt_dec  = cnt_q - CW'(1);

	// A pop only touches the memory when the stack holds something; otherwise the
	// popped value is the empty marker and the underflow flag is raised.
	assign ram_rd_en   = pop_req && !empty;
	assign ram_rd_addr = cnt_dec[AW-1:0];
	assign ram_wr_en   = push_req && !full;
	assign ram_wr_addr = cnt_q[AW-1:0];

	// Value of the pop issued in the previous cycle.
	assign pop_value = pop_mem_q ? ram_rd_data : EMPTY_WORD;

	assign abs_left  = left_q[WORD_W-1]  ? (~left_q + WORD_W'(1))  : left_q;
	assign abs_right = right_q[WORD_W-1] ? (~right_q + WORD_W'(1)) : right_q;

	// One restoring division step: bring down the next dividend bit and try to subtract.
	assign rem_sh    = {rem_q, quo_q[WORD_W-1]};
	assign rem_ge    = rem_sh >= {1'b0, dvs_q};
	assign quo_final = neg_q ? (~quo_q + WORD_W'(1)) : quo_q;

	pse_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(push_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!in_digit) begin
						state_d = ST_POP_L;
					end else if (in_word.is_last) begin
						state_d = ST_FIN_RD;
					end
				end
			end
			ST_POP_L: state_d = ST_OPER;
			ST_OPER:  state_d = ST_EXEC;
			ST_EXEC: begin
				if (sym_q == SYM_DIV && right_q != '0) begin
					state_d = ST_DIV;
				end else if (last_q) begin
					state_d = ST_FIN_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_END;
				end
			end
			ST_DIV_END: state_d = last_q ? ST_FIN_RD : ST_IDLE;
			ST_FIN_RD:  state_d = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		in_ready  = 1'b0;
		pop_req   = 1'b0;
		push_req  = 1'b0;
		push_data = '0;
		divz_set  = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// A digit is pushed straight away; anything else pops its right operand.
					push_req  = in_digit;
					pop_req   = !in_digit;
					push_data = {{(WORD_W-8){1'b0}}, in_word.symbol - SYM_ZERO};
				end
			end
			ST_POP_L: pop_req = 1'b1;
			ST_OPER: begin
			end
			ST_EXEC: begin
				unique case (sym_q)
					SYM_ADD: begin
						push_req  = 1'b1;
						push_data = left_q + right_q;
					end
					SYM_SUB: begin
						push_req  = 1'b1;
						push_data = left_q - right_q;
					end
					SYM_MUL: begin
						push_req  = 1'b1;
						push_data = left_q * right_q;
					end
					SYM_DIV: begin
						// A zero divisor pushes zero here; otherwise the divider takes over.
						if (right_q == '0) begin
							push_req = 1'b1;
							divz_set = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ST_DIV: begin
			end
			ST_DIV_END: begin
				push_req  = 1'b1;
				push_data = quo_final;
			end
			ST_FIN_RD: pop_req = 1'b1;
			ST_FIN:    emit    = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stack depth and sticky error flags; both clear when the result is handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			flags_q <= '0;
		end else if (emit) begin
			cnt_q   <= '0;
			flags_q <= '0;
		end else begin
			if (ram_wr_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ram_rd_en) begin
				cnt_q <= cnt_dec;
			end
			if (pop_req && empty) begin
				flags_q.underflow <= 1'b1;
			end
			if (push_req && full) begin
				flags_q.overflow <= 1'b1;
			end
			if (divz_set) begin
				flags_q.div_by_zero <= 1'b1;
			end
		end
	end

	// Operand and divider data path.
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= in_word.symbol;
			last_q <= in_word.is_last;
		end
		if (pop_req) begin
			pop_mem_q <= !empty;
		end
		if (state_q == ST_POP_L) begin
			right_q <= pop_value;
		end
		if (state_q == ST_OPER) begin
			left_q <= pop_value;
		end
		if (state_q == ST_EXEC) begin
			rem_q  <= '0;
			quo_q  <= abs_left;
			dvs_q  <= abs_right;
			neg_q  <= left_q[WORD_W-1] ^ right_q[WORD_W-1];
			step_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (rem_ge) begin
				rem_q <= WORD_W'(rem_sh - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_sh[WORD_W-1:0];
			end
			quo_q  <= {quo_q[WORD_W-2:0], rem_ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Result register: the final pop arrives from the memory in ST_FIN.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q.value       <= pop_value;
			out_word_q.underflow   <= flags_q.underflow;
			out_word_q.overflow    <= flags_q.overflow;
			out_word_q.div_by_zero <= flags_q.div_by_zero;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// The stack count can never pass the memory depth.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_COUNT)
		else $error("stack count beyond depth");

	// The single memory port pair is never asked to push and pop in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(ram_rd_en && ram_wr_en))
		else $error("push and pop in the same cycle");

	// Handing over a result leaves an empty stack, clear flags and a valid result word.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (cnt_q == '0 && flags_q == '0 && out_valid_q))
		else $error("state not cleared after result");

	// A division with a nonzero divisor always runs the divider.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && sym_q == SYM_DIV && right_q != '0) |=> state_q == ST_DIV)
		else $error("divider not started");

	// The quotient is only pushed after the last divider iteration.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_END |-> $past(state_q) == ST_DIV)
		else $error("quotient pushed without division");

endmodule
